>>> rtl/cdcnt_pkg.sv
// Package for the calendar date counter: widths, command and status codes,
// controller/datapath command and status structs and the month length table.
// No dependencies.
`default_nettype none

package cdcnt_pkg;

   localparam int YEAR_W    = 14;
   localparam int MONTH_W   = 4;
   localparam int DAY_W     = 5;
   localparam int TEXT_W    = 64;
   localparam int COUNT_W   = 16;
   localparam int CMD_W     = 2;
   localparam int STAT_W    = 2;
   localparam int BCD_W     = 16;
   localparam int CVT_CNT_W = $clog2(YEAR_W);

   localparam int COUNT_BITS_DEFAULT = 16;

   localparam logic [YEAR_W-1:0]  MAX_YEAR        = 14'd9999;
   localparam logic [BCD_W-1:0]   RESET_YEAR_BCD  = 16'h1900;
   localparam logic [BCD_W-1:0]   MAX_YEAR_BCD    = 16'h9999;
   localparam logic [MONTH_W-1:0] MONTH_FIRST     = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_LAST      = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FIRST       = 5'd1;
   localparam logic [3:0]         ASCII_DIGIT_HI  = 4'h3;
   localparam logic [3:0]         DIGIT_MAX       = 4'd9;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET_NUM  = 2'd0,
      CMD_SET_TEXT = 2'd1,
      CMD_ADD      = 2'd2,
      CMD_READ     = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_TEXT  = 2'd1,
      STAT_BAD_VALUE = 2'd2,
      STAT_OVERFLOW  = 2'd3
   } status_type;

   typedef struct packed {
      logic accept;
      logic cvt_step;
      logic adv_step;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic num_valid;
      logic cvt_last;
      logic adv_done;
   } dp_stat_type;

   function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] month, logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         4'd2:                     len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
         default:                  len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

>>> rtl/cdcnt_if.sv
// Request and response channel interfaces of the calendar date counter.
// Depends on cdcnt_pkg.
`default_nettype none

interface cdcnt_req_if;
   logic                                valid;
   logic                                ready;
   logic [cdcnt_pkg::CMD_W-1:0]         command;
   logic [cdcnt_pkg::YEAR_W-1:0]        set_year;
   logic [cdcnt_pkg::MONTH_W-1:0]       set_month;
   logic [cdcnt_pkg::DAY_W-1:0]         set_day;
   logic [cdcnt_pkg::TEXT_W-1:0]        date_text;
   logic [cdcnt_pkg::COUNT_W-1:0]       day_count;

   modport source (output valid, command, set_year, set_month, set_day, date_text,
                   day_count, input ready);
   modport sink   (input valid, command, set_year, set_month, set_day, date_text,
                   day_count, output ready);
endinterface

interface cdcnt_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [cdcnt_pkg::YEAR_W-1:0]        out_year;
   logic [cdcnt_pkg::MONTH_W-1:0]       out_month;
   logic [cdcnt_pkg::DAY_W-1:0]         out_day;
   logic [cdcnt_pkg::TEXT_W-1:0]        out_text;
   logic [cdcnt_pkg::STAT_W-1:0]        status;

   modport source (output valid, out_year, out_month, out_day, out_text, status,
                   input ready);
   modport sink   (input valid, out_year, out_month, out_day, out_text, status,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/cdcnt_datapath.sv
// Datapath of the calendar date counter: date registers (BCD year), text parse,
// binary-to-BCD converter, month-step advance and the response register.
// Depends on cdcnt_pkg.
`default_nettype none

module cdcnt_datapath #(
   parameter int COUNT_BITS = cdcnt_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cdcnt_pkg::dp_cmd_type              cmd,
   output cdcnt_pkg::dp_stat_type             stat,
   input  logic [cdcnt_pkg::CMD_W-1:0]        command,
   input  logic [cdcnt_pkg::YEAR_W-1:0]       set_year,
   input  logic [cdcnt_pkg::MONTH_W-1:0]      set_month,
   input  logic [cdcnt_pkg::DAY_W-1:0]        set_day,
   input  logic [cdcnt_pkg::TEXT_W-1:0]       date_text,
   input  logic [cdcnt_pkg::COUNT_W-1:0]      day_count,
   output logic [cdcnt_pkg::YEAR_W-1:0]       out_year,
   output logic [cdcnt_pkg::MONTH_W-1:0]      out_month,
   output logic [cdcnt_pkg::DAY_W-1:0]        out_day,
   output logic [cdcnt_pkg::TEXT_W-1:0]       out_text,
   output logic [cdcnt_pkg::STAT_W-1:0]       status
);

   localparam int YW = cdcnt_pkg::YEAR_W;
   localparam int MW = cdcnt_pkg::MONTH_W;
   localparam int DW = cdcnt_pkg::DAY_W;
   localparam int BW = cdcnt_pkg::BCD_W;
   localparam int CW = cdcnt_pkg::CVT_CNT_W;
   localparam logic [CW-1:0] CVT_LAST = CW'(YW - 1);

   function automatic logic [BW-1:0] bcd_inc(logic [BW-1:0] v);
      logic [BW-1:0] r;
      logic          carry;
      r     = v;
      carry = 1'b1;
      for (int i = 0; i < BW / 4; i++) begin
         if (carry) begin
            if (v[4*i +: 4] == cdcnt_pkg::DIGIT_MAX) begin
               r[4*i +: 4] = 4'd0;
            end else begin
               r[4*i +: 4] = v[4*i +: 4] + 4'd1;
               carry       = 1'b0;
            end
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] to_bcd2(logic [DW-1:0] v);
      logic [3:0] tens;
      logic [3:0] ones;
      priority if (v >= 5'd30) begin
         tens = 4'd3;
         ones = 4'(v - 5'd30);
      end else if (v >= 5'd20) begin
         tens = 4'd2;
         ones = 4'(v - 5'd20);
      end else if (v >= 5'd10) begin
         tens = 4'd1;
         ones = 4'(v - 5'd10);
      end else begin
         tens = 4'd0;
         ones = 4'(v);
      end
      return {tens, ones};
   endfunction

   logic [BW-1:0]          ybcd_ff, ybcd_in;
   logic [MW-1:0]          month_ff, month_in;
   logic [DW-1:0]          day_ff, day_in;
   logic [COUNT_BITS-1:0]  cnt_ff, cnt_in;
   cdcnt_pkg::status_type  status_ff, status_in;
   logic [YW-1:0]          dd_bin_ff, dd_bin_in;
   logic [BW-1:0]          dd_bcd_ff, dd_bcd_in;
   logic [CW-1:0]          cvt_cnt_ff, cvt_cnt_in;

   logic [YW-1:0]          rsp_year_ff;
   logic [MW-1:0]          rsp_month_ff;
   logic [DW-1:0]          rsp_day_ff;
   logic [cdcnt_pkg::TEXT_W-1:0] rsp_text_ff;
   logic [cdcnt_pkg::STAT_W-1:0] rsp_status_ff;

   // leap year from BCD digits
   logic [1:0]    lo_mod, hi_mod;
   logic          yy_zero, leap;
   logic [DW-1:0] mlen, step_days;
   logic [31:0]   cnt_wide, step_wide, day_sum, cnt_dec, count_ext;
   logic          year_max;
   logic [BW-1:0] dd_adj, dd_shift;

   logic [3:0]    tdig [8];
   logic          text_digits;
   logic [6:0]    t_month, t_day;
   logic          text_range, num_ok;

   logic [YW-1:0] year_bin;
   logic [7:0]    mon_bcd, day_bcd;

   assign yy_zero   = (ybcd_ff[7:0] == 8'h00);
   assign lo_mod    = 2'({ybcd_ff[4], 1'b0} + ybcd_ff[1:0]);
   assign hi_mod    = 2'({ybcd_ff[12], 1'b0} + ybcd_ff[9:8]);
   assign leap      = yy_zero ? (hi_mod == 2'd0) : (lo_mod == 2'd0);
   assign mlen      = cdcnt_pkg::month_len(month_ff, leap);
   assign step_days = (day_ff > mlen) ? DW'(1) : DW'(mlen - day_ff + DW'(1));
   assign cnt_wide  = 32'(cnt_ff);
   assign step_wide = 32'(step_days);
   assign day_sum   = 32'(day_ff) + cnt_wide;
   assign cnt_dec   = cnt_wide - step_wide;
   assign count_ext = 32'(day_count);
   assign year_max  = (ybcd_ff == cdcnt_pkg::MAX_YEAR_BCD);

   always_comb begin
      for (int i = 0; i < BW / 4; i++) begin
         dd_adj[4*i +: 4] = (dd_bcd_ff[4*i +: 4] >= 4'd5) ? dd_bcd_ff[4*i +: 4] + 4'd3
                                                          : dd_bcd_ff[4*i +: 4];
      end
   end
   assign dd_shift = {dd_adj[BW-2:0], dd_bin_ff[YW-1]};

   always_comb begin
      text_digits = 1'b1;
      for (int i = 0; i < 8; i++) begin
         tdig[i] = date_text[cdcnt_pkg::TEXT_W-1-8*i-4 -: 4];
         if (date_text[cdcnt_pkg::TEXT_W-1-8*i -: 4] != cdcnt_pkg::ASCII_DIGIT_HI ||
             date_text[cdcnt_pkg::TEXT_W-1-8*i-4 -: 4] > cdcnt_pkg::DIGIT_MAX) begin
            text_digits = 1'b0;
         end
      end
   end

   assign t_month    = 7'(tdig[4]) * 7'd10 + 7'(tdig[5]);
   assign t_day      = 7'(tdig[6]) * 7'd10 + 7'(tdig[7]);
   assign text_range = (t_month >= 7'd1) && (t_month <= 7'd12) &&
                       (t_day >= 7'd1) && (t_day <= 7'd31);
   assign num_ok     = (set_year <= cdcnt_pkg::MAX_YEAR) &&
                       (set_month >= cdcnt_pkg::MONTH_FIRST) &&
                       (set_month <= cdcnt_pkg::MONTH_LAST) &&
                       (set_day >= cdcnt_pkg::DAY_FIRST);

   always_comb begin
      ybcd_in    = ybcd_ff;
      month_in   = month_ff;
      day_in     = day_ff;
      cnt_in     = cnt_ff;
      status_in  = status_ff;
      dd_bin_in  = dd_bin_ff;
      dd_bcd_in  = dd_bcd_ff;
      cvt_cnt_in = cvt_cnt_ff;
      if (cmd.accept) begin
         cvt_cnt_in = '0;
         dd_bin_in  = set_year;
         dd_bcd_in  = '0;
         cnt_in     = count_ext[COUNT_BITS-1:0];
         status_in  = cdcnt_pkg::STAT_OK;
         unique case (cdcnt_pkg::cmd_type'(command))
            cdcnt_pkg::CMD_SET_NUM: begin
               if (num_ok) begin
                  month_in = set_month;
                  day_in   = set_day;
               end else begin
                  status_in = cdcnt_pkg::STAT_BAD_VALUE;
               end
            end
            cdcnt_pkg::CMD_SET_TEXT: begin
               priority if (!text_digits) begin
                  status_in = cdcnt_pkg::STAT_BAD_TEXT;
               end else if (!text_range) begin
                  status_in = cdcnt_pkg::STAT_BAD_VALUE;
               end else begin
                  ybcd_in  = {tdig[0], tdig[1], tdig[2], tdig[3]};
                  month_in = t_month[MW-1:0];
                  day_in   = t_day[DW-1:0];
               end
            end
            cdcnt_pkg::CMD_ADD: begin
               status_in = cdcnt_pkg::STAT_OK;
            end
            cdcnt_pkg::CMD_READ: begin
               status_in = cdcnt_pkg::STAT_OK;
            end
         endcase
      end else if (cmd.cvt_step) begin
         dd_bin_in  = {dd_bin_ff[YW-2:0], 1'b0};
         dd_bcd_in  = dd_shift;
         cvt_cnt_in = cvt_cnt_ff + CW'(1);
         if (cvt_cnt_ff == CVT_LAST) begin
            ybcd_in = dd_shift;
         end
      end else if (cmd.adv_step && cnt_ff != '0) begin
         if (cnt_wide >= step_wide) begin
            if (month_ff == cdcnt_pkg::MONTH_LAST) begin
               if (year_max) begin
                  day_in    = mlen;
                  cnt_in    = '0;
                  status_in = cdcnt_pkg::STAT_OVERFLOW;
               end else begin
                  ybcd_in  = bcd_inc(ybcd_ff);
                  month_in = cdcnt_pkg::MONTH_FIRST;
                  day_in   = cdcnt_pkg::DAY_FIRST;
                  cnt_in   = cnt_dec[COUNT_BITS-1:0];
               end
            end else begin
               month_in = month_ff + MW'(1);
               day_in   = cdcnt_pkg::DAY_FIRST;
               cnt_in   = cnt_dec[COUNT_BITS-1:0];
            end
         end else begin
            day_in = day_sum[DW-1:0];
            cnt_in = '0;
         end
      end
   end

   assign year_bin = YW'(ybcd_ff[15:12]) * YW'(1000) + YW'(ybcd_ff[11:8]) * YW'(100) +
                     YW'(ybcd_ff[7:4]) * YW'(10) + YW'(ybcd_ff[3:0]);
   assign mon_bcd  = to_bcd2(DW'(month_ff));
   assign day_bcd  = to_bcd2(day_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ybcd_ff    <= cdcnt_pkg::RESET_YEAR_BCD;
         month_ff   <= cdcnt_pkg::MONTH_FIRST;
         day_ff     <= cdcnt_pkg::DAY_FIRST;
         cnt_ff     <= '0;
         cvt_cnt_ff <= '0;
      end else begin
         ybcd_ff    <= ybcd_in;
         month_ff   <= month_in;
         day_ff     <= day_in;
         cnt_ff     <= cnt_in;
         cvt_cnt_ff <= cvt_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      dd_bin_ff <= dd_bin_in;
      dd_bcd_ff <= dd_bcd_in;
      if (cmd.rsp_load) begin
         rsp_year_ff   <= year_bin;
         rsp_month_ff  <= month_ff;
         rsp_day_ff    <= day_ff;
         rsp_text_ff   <= {cdcnt_pkg::ASCII_DIGIT_HI, ybcd_ff[15:12],
                           cdcnt_pkg::ASCII_DIGIT_HI, ybcd_ff[11:8],
                           cdcnt_pkg::ASCII_DIGIT_HI, ybcd_ff[7:4],
                           cdcnt_pkg::ASCII_DIGIT_HI, ybcd_ff[3:0],
                           cdcnt_pkg::ASCII_DIGIT_HI, mon_bcd[7:4],
                           cdcnt_pkg::ASCII_DIGIT_HI, mon_bcd[3:0],
                           cdcnt_pkg::ASCII_DIGIT_HI, day_bcd[7:4],
                           cdcnt_pkg::ASCII_DIGIT_HI, day_bcd[3:0]};
         rsp_status_ff <= status_ff;
      end
   end

   assign stat.num_valid = num_ok;
   assign stat.cvt_last  = (cvt_cnt_ff == CVT_LAST);
   assign stat.adv_done  = (cnt_ff == '0);

   assign out_year  = rsp_year_ff;
   assign out_month = rsp_month_ff;
   assign out_day   = rsp_day_ff;
   assign out_text  = rsp_text_ff;
   assign status    = rsp_status_ff;

`ifndef SYNTHESIS
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      month_ff >= cdcnt_pkg::MONTH_FIRST && month_ff <= cdcnt_pkg::MONTH_LAST)
      else $error("month register out of range");

   a_day_year_digits: assert property (@(posedge clock) disable iff (reset)
      day_ff != '0 && ybcd_ff[15:12] <= cdcnt_pkg::DIGIT_MAX &&
      ybcd_ff[11:8] <= cdcnt_pkg::DIGIT_MAX && ybcd_ff[7:4] <= cdcnt_pkg::DIGIT_MAX &&
      ybcd_ff[3:0] <= cdcnt_pkg::DIGIT_MAX)
      else $error("day is zero or year digit is not decimal");

   a_advance_progress: assert property (@(posedge clock) disable iff (reset)
      cmd.adv_step && cnt_ff != '0 |=> cnt_ff < $past(cnt_ff))
      else $error("advance step did not reduce the day count");
`endif

endmodule

`default_nettype wire

>>> rtl/cdcnt_ctrl.sv
// Controller of the calendar date counter: sequences accept, conversion,
// advance and response load for the datapath. Depends on cdcnt_pkg.
`default_nettype none

module cdcnt_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cdcnt_pkg::CMD_W-1:0]   command,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output cdcnt_pkg::dp_cmd_type         cmd,
   input  cdcnt_pkg::dp_stat_type        stat
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_ADVANCE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign cmd.accept   = accept;
   assign cmd.cvt_step = (state_ff == ST_CONVERT);
   assign cmd.adv_step = (state_ff == ST_ADVANCE);
   assign cmd.rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (cdcnt_pkg::cmd_type'(command))
                  cdcnt_pkg::CMD_SET_NUM:  state_in = stat.num_valid ? ST_CONVERT : ST_FINISH;
                  cdcnt_pkg::CMD_SET_TEXT: state_in = ST_FINISH;
                  cdcnt_pkg::CMD_ADD:      state_in = ST_ADVANCE;
                  cdcnt_pkg::CMD_READ:     state_in = ST_FINISH;
               endcase
            end
         end
         ST_CONVERT: begin
            if (stat.cvt_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_ADVANCE: begin
            if (stat.adv_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (cmd.rsp_load) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request taken while previous request still in progress");
`endif

endmodule

`default_nettype wire

>>> rtl/calendar_date_counter_unit.sv
// Calendar date counter top level: request/response channels, controller
// and datapath. Depends on cdcnt_pkg, cdcnt_if, cdcnt_ctrl, cdcnt_datapath.
`default_nettype none

// Holds a Gregorian date (reset 1900-01-01) and runs one request at a time:
// set from numbers, set from eight ASCII digits YYYYMMDD, advance by a day
// count, or read; each request returns the date as numbers and as text plus
// a status. Read, text set and rejected sets go straight to the finish state,
// where the response is loaded once the previous one has been taken. A numeric
// set first runs a bit-serial binary-to-BCD conversion of the year. An advance
// steps one month boundary per cycle in the datapath until the day count is
// used up. A new request is taken once the previous response is loaded into
// the response register.
module calendar_date_counter_unit #(
   parameter int COUNT_BITS = cdcnt_pkg::COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   cdcnt_req_if.sink   req_chan,
   cdcnt_rsp_if.source rsp_chan
);

   cdcnt_pkg::dp_cmd_type  dp_cmd;
   cdcnt_pkg::dp_stat_type dp_stat;

   cdcnt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .command   (req_chan.command),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (dp_cmd),
      .stat      (dp_stat)
   );

   cdcnt_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (dp_cmd),
      .stat      (dp_stat),
      .command   (req_chan.command),
      .set_year  (req_chan.set_year),
      .set_month (req_chan.set_month),
      .set_day   (req_chan.set_day),
      .date_text (req_chan.date_text),
      .day_count (req_chan.day_count),
      .out_year  (rsp_chan.out_year),
      .out_month (rsp_chan.out_month),
      .out_day   (rsp_chan.out_day),
      .out_text  (rsp_chan.out_text),
      .status    (rsp_chan.status)
   );

endmodule

`default_nettype wire
